FILE: design/rcrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcrb_pkg: shared codes and types for the reserve/commit ring buffer
// Operation and status codes, field widths and the control bundle between
// the sequencer and the slot store.
// ----------------------------------------------------------------------------
package rcrb_pkg;

  // Fixed field widths of the item ports
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_COMMIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  // Store controls driven by the sequencer
  typedef struct packed {
    logic commit_wr;    // write payload and set ready mark at the write index
    logic release_clr;  // clear ready mark at the head index
    logic peek_rd;      // register the head payload
  } rcrb_ctl_t;

endpackage

FILE: design/rcrb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcrb_store: slot payload memory and ready marks
// Payload words sit in a memory with one write and one registered read port.
// Ready marks are flip-flops, cleared by reset, read at two indexes.
// ----------------------------------------------------------------------------
module rcrb_store import rcrb_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int PTR_W     = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rcrb_ctl_t            ctl,
  input  logic [PTR_W-1:0]     wr_idx,
  input  logic [PTR_W-1:0]     head_idx,
  input  logic [PTR_W-1:0]     walk_idx,
  input  logic [PAYLOAD_W-1:0] wr_data,
  output logic [PAYLOAD_W-1:0] rd_data,
  output logic                 chk_ready,
  output logic                 walk_ready
);

  logic [PAYLOAD_W-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] ready;

  // Write committed payload, register head payload on peek
  always_ff @(posedge clk) begin
    if (ctl.commit_wr) begin
      mem[wr_idx] <= wr_data;
    end
    if (ctl.peek_rd) begin
      rd_data <= mem[head_idx];
    end
  end

  // Set mark on commit, clear mark on release
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
    end else begin
      if (ctl.commit_wr) begin
        ready[wr_idx] <= 1'b1;
      end
      if (ctl.release_clr) begin
        ready[head_idx] <= 1'b0;
      end
    end
  end

  assign chk_ready  = ready[wr_idx];
  assign walk_ready = ready[walk_idx];

endmodule

FILE: design/reserve_commit_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reserve_commit_ring_buffer: ring of slots with reserve, commit and read
// Sequencer, pointers and result register around the slot store.
// ----------------------------------------------------------------------------
// One item is handled at a time. After acceptance the block executes the
// operation and then offers the result, and it returns to idle and takes
// the next item only after the result is taken. An accepted commit also
// walks the commit pointer over consecutive ready slots through a single
// compare-and-step unit, one slot per cycle, until it reaches the reserve
// pointer or an unready slot; the pointer advances by at most NUM_SLOTS - 1.
// Status codes: 0 ok, 1 full, 2 empty, 3 invalid commit or release
// (ignored). Slot indexes on the ports are 4 bits wide; a commit to a slot
// at or beyond NUM_SLOTS is rejected.
// ----------------------------------------------------------------------------
module reserve_commit_ring_buffer import rcrb_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      operation,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [PAYLOAD_W-1:0] payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W-1:0]    slot_out,
  output logic [PAYLOAD_W-1:0] payload_out
);

  localparam int PTR_W = $clog2(NUM_SLOTS);
  localparam int CMP_W = ((PTR_W > SLOT_W) ? PTR_W : SLOT_W) + 1;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]           state;
  logic [OP_W-1:0]      op_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [PAYLOAD_W-1:0] payload_r;
  logic [PTR_W-1:0]     rsv_ptr;
  logic [PTR_W-1:0]     cmt_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [STATUS_W-1:0]  status_r;
  logic [SLOT_W-1:0]    slot_out_r;
  logic                 peek_hit;

  rcrb_ctl_t            ctl;
  logic [PTR_W-1:0]     slot_idx;
  logic [PAYLOAD_W-1:0] rd_data;
  logic                 chk_ready;
  logic                 walk_ready;
  logic                 slot_in_range;
  logic                 commit_ok;
  logic                 ring_full;
  logic                 ring_empty;

  // Step a pointer around the ring
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(NUM_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Circular distance from one pointer to another
  function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] from,
                                                 input logic [PTR_W-1:0] to);
    logic [PTR_W:0] d;
    d = {1'b0, to} + (PTR_W+1)'(NUM_SLOTS) - {1'b0, from};
    if (d >= (PTR_W+1)'(NUM_SLOTS)) begin
      d = d - (PTR_W+1)'(NUM_SLOTS);
    end
    return d[PTR_W-1:0];
  endfunction

  assign slot_idx      = PTR_W'(slot_r);
  assign slot_in_range = CMP_W'(slot_r) < CMP_W'(NUM_SLOTS);
  assign commit_ok     = slot_in_range && !chk_ready &&
                         (ring_dist(cmt_ptr, slot_idx) < ring_dist(cmt_ptr, rsv_ptr));
  assign ring_full     = ring_next(rsv_ptr) == rd_ptr;
  assign ring_empty    = rd_ptr == cmt_ptr;

  // Drive store controls during execution
  always_comb begin
    ctl = '0;
    if (state == S_EXEC) begin
      unique case (op_r)
        OP_COMMIT:  ctl.commit_wr   = commit_ok;
        OP_PEEK:    ctl.peek_rd     = !ring_empty;
        OP_RELEASE: ctl.release_clr = !ring_empty;
        default:    ctl = '0;
      endcase
    end
  end

  rcrb_store #(
    .NUM_SLOTS  (NUM_SLOTS),
    .PTR_W      (PTR_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .wr_idx     (slot_idx),
    .head_idx   (rd_ptr),
    .walk_idx   (cmt_ptr),
    .wr_data    (payload_r),
    .rd_data    (rd_data),
    .chk_ready  (chk_ready),
    .walk_ready (walk_ready)
  );

  // Latch the item, execute, walk the commit pointer, hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rsv_ptr <= '0;
      cmt_ptr <= '0;
      rd_ptr  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          unique case (op_r)
            OP_RESERVE: begin
              if (!ring_full) begin
                rsv_ptr <= ring_next(rsv_ptr);
              end
            end
            OP_COMMIT: begin
              if (commit_ok) begin
                state <= S_WALK;
              end
            end
            OP_RELEASE: begin
              if (!ring_empty) begin
                rd_ptr <= ring_next(rd_ptr);
              end
            end
            default: begin
            end
          endcase
        end
        S_WALK: begin
          if (cmt_ptr == rsv_ptr || !walk_ready) begin
            state <= S_OUT;
          end else begin
            cmt_ptr <= ring_next(cmt_ptr);
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture item fields and form the result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r      <= operation;
      slot_r    <= slot;
      payload_r <= payload;
    end
    if (state == S_EXEC) begin
      status_r   <= ST_OK;
      slot_out_r <= '0;
      peek_hit   <= 1'b0;
      unique case (op_r)
        OP_RESERVE: begin
          if (ring_full) begin
            status_r <= ST_FULL;
          end else begin
            slot_out_r <= SLOT_W'(rsv_ptr);
          end
        end
        OP_COMMIT: begin
          if (!commit_ok) begin
            status_r <= ST_INVALID;
          end
        end
        OP_PEEK: begin
          if (ring_empty) begin
            status_r <= ST_EMPTY;
          end else begin
            slot_out_r <= SLOT_W'(rd_ptr);
            peek_hit   <= 1'b1;
          end
        end
        OP_RELEASE: begin
          if (ring_empty) begin
            status_r <= ST_INVALID;
          end
        end
        default: status_r <= ST_OK;
      endcase
    end
  end

  assign in_stall    = state != S_IDLE;
  assign out_valid   = state == S_OUT;
  assign status      = status_r;
  assign slot_out    = slot_out_r;
  assign payload_out = peek_hit ? rd_data : '0;

`ifndef SYNTHESIS
  // No item is taken while a result waits
  a_no_accept_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item accepted while result pending");

  // Commit pointer stays between read and reserve pointers
  a_cmt_bounded: assert property (@(posedge clk) disable iff (rst)
    ring_dist(rd_ptr, cmt_ptr) <= ring_dist(rd_ptr, rsv_ptr))
    else $error("commit pointer outside read..reserve range");

  // An empty answer means the head has caught up with commits
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (rd_ptr == cmt_ptr))
    else $error("empty reported with committed slots pending");

  // Walk stops only at the reserve pointer or an unready slot
  a_walk_stop: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && $past(state) == S_WALK && cmt_ptr == $past(cmt_ptr))
      |-> (cmt_ptr == rsv_ptr || !walk_ready))
    else $error("commit walk stalled on a ready slot");
`endif

endmodule
